// ----- rtl/core/idq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed deque store package
// Operation and status codes, field widths, defaults and the command control
// word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package idq_pkg;

  localparam int OP_BITS     = 3;
  localparam int VALUE_BITS  = 32;
  localparam int INDEX_BITS  = 6;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 7;

  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_READ_AT    = 3'd4;
  localparam logic [OP_BITS-1:0] OP_WRITE_AT   = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                   wr;
    logic                   rd;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  count;
  } cmd_ctrl_t;

endpackage

// ----- rtl/core/idq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed deque store channels
// Request channel (op, value, index) and response channel (status,
// read_value, count), each with valid/ready.
// ----------------------------------------------------------------------------
interface idq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [idq_pkg::OP_BITS-1:0]    op;
  logic signed [idq_pkg::VALUE_BITS-1:0] value;
  logic        [idq_pkg::INDEX_BITS-1:0] index;

  modport source (output valid, op, value, index, input ready);
  modport sink   (input valid, op, value, index, output ready);
endinterface

interface idq_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic        [idq_pkg::STATUS_BITS-1:0] status;
  logic signed [idq_pkg::VALUE_BITS-1:0]  read_value;
  logic        [idq_pkg::COUNT_BITS-1:0]  count;

  modport source (output valid, status, read_value, count, input ready);
  modport sink   (input valid, status, read_value, count, output ready);
endinterface

// ----- rtl/core/indexed_deque_store_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed deque store unit
// Bounded double-ended queue of words in a ring buffer, with push and pop at
// both ends and read or overwrite at a position counted from the front.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     word
//  req      in   valid/ready   op, value, index
//  rsp      out  valid/ready   status, read_value, count
//
//  One request per cycle sustained while responses are taken; each response
//  passes through a command queue slot, then the memory port and output
//  register of the back end, before it is offered.
//  Reset clears head slot, count and queue control; entry memory is not cleared.
//  A stalled response fills the two-entry command queue, then req.ready drops.
// ----------------------------------------------------------------------------
module indexed_deque_store_unit #(
  parameter int DEPTH     = idq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = idq_pkg::WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  idq_req_if.sink   req,
  idq_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CMD_BITS = $bits(idq_pkg::cmd_ctrl_t) + AW + WORD_BITS;

  logic                 f_push, q_full, q_valid, q_pop;
  idq_pkg::cmd_ctrl_t   f_ctrl, q_ctrl;
  logic [AW-1:0]        f_slot, q_slot;
  logic [WORD_BITS-1:0] f_value, q_value;
  logic [CMD_BITS-1:0]  q_data;

  idq_front #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_full  (q_full),
    .cmd_push  (f_push),
    .cmd_ctrl  (f_ctrl),
    .cmd_slot  (f_slot),
    .cmd_value (f_value)
  );

  idq_cmd_fifo #(
    .WIDTH (CMD_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_ctrl, f_slot, f_value}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  assign {q_ctrl, q_slot, q_value} = q_data;

  idq_back #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ctrl  (q_ctrl),
    .cmd_slot  (q_slot),
    .cmd_value (q_value),
    .cmd_pop   (q_pop),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/core/idq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed deque store front end
// Accepts requests, keeps head slot and count, classifies each request and
// issues a memory command with its status and resulting count.
// ----------------------------------------------------------------------------
module idq_front #(
  parameter int DEPTH     = idq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = idq_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  idq_req_if.sink                       req,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output idq_pkg::cmd_ctrl_t            cmd_ctrl,
  output logic [$clog2(DEPTH)-1:0]      cmd_slot,
  output logic [WORD_BITS-1:0]          cmd_value
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int XA  = (AW + 1 > idq_pkg::COUNT_BITS) ? AW + 1 : idq_pkg::COUNT_BITS;
  localparam int XW  = (XA > CW) ? XA : CW;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_S   = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

  logic [AW-1:0] head_slot, head_slot_next;
  logic [CW-1:0] entry_count, entry_count_next;

  logic          accept;
  logic          full, empty, idx_ok;
  logic [XW-1:0] cnt_x, idx_x, cnt_next_x;
  logic [AW:0]   pos, sum;
  logic [AW-1:0] slot_at, head_dec, head_inc;
  idq_pkg::cmd_ctrl_t ctrl;

  assign req.ready = !cmd_full;
  assign accept    = req.valid && !cmd_full;

  assign cnt_x  = XW'(entry_count);
  assign idx_x  = XW'(req.index);
  assign full   = (entry_count == DEPTH_C);
  assign empty  = (entry_count == '0);
  assign idx_ok = (idx_x < cnt_x);

  always_comb begin
    if (req.op == idq_pkg::OP_PUSH_REAR) begin
      pos = cnt_x[AW:0];
    end else begin
      pos = idx_x[AW:0];
    end
    sum = {1'b0, head_slot} + pos;
    if (sum >= DEPTH_S) begin
      slot_at = AW'(sum - DEPTH_S);
    end else begin
      slot_at = sum[AW-1:0];
    end
    head_dec = (head_slot == '0) ? LAST_SLOT : head_slot - 1'b1;
    head_inc = (head_slot == LAST_SLOT) ? '0 : head_slot + 1'b1;
  end

  always_comb begin
    head_slot_next   = head_slot;
    entry_count_next = entry_count;
    ctrl.wr          = 1'b0;
    ctrl.rd          = 1'b0;
    ctrl.status      = idq_pkg::ST_OK;
    cmd_slot         = slot_at;
    unique case (req.op)
      idq_pkg::OP_PUSH_FRONT: begin
        cmd_slot = head_dec;
        if (full) begin
          ctrl.status = idq_pkg::ST_FULL;
        end else begin
          ctrl.wr          = 1'b1;
          head_slot_next   = head_dec;
          entry_count_next = entry_count + 1'b1;
        end
      end
      idq_pkg::OP_PUSH_REAR: begin
        if (full) begin
          ctrl.status = idq_pkg::ST_FULL;
        end else begin
          ctrl.wr          = 1'b1;
          entry_count_next = entry_count + 1'b1;
        end
      end
      idq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          ctrl.status = idq_pkg::ST_EMPTY;
        end else begin
          head_slot_next   = head_inc;
          entry_count_next = entry_count - 1'b1;
        end
      end
      idq_pkg::OP_POP_REAR: begin
        if (empty) begin
          ctrl.status = idq_pkg::ST_EMPTY;
        end else begin
          entry_count_next = entry_count - 1'b1;
        end
      end
      idq_pkg::OP_READ_AT: begin
        if (idx_ok) begin
          ctrl.rd = 1'b1;
        end else begin
          ctrl.status = idq_pkg::ST_BAD_INDEX;
        end
      end
      idq_pkg::OP_WRITE_AT: begin
        if (idx_ok) begin
          ctrl.wr = 1'b1;
        end else begin
          ctrl.status = idq_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
      end
    endcase
    cnt_next_x = XW'(entry_count_next);
    ctrl.count = cnt_next_x[idq_pkg::COUNT_BITS-1:0];
  end

  assign cmd_push  = accept;
  assign cmd_ctrl  = ctrl;
  assign cmd_value = WORD_BITS'($unsigned(req.value));

  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot   <= '0;
      entry_count <= '0;
    end else if (accept) begin
      head_slot   <= head_slot_next;
      entry_count <= entry_count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= DEPTH_C)
    else $error("entry count above depth");

  a_empty_pop_holds: assert property (@(posedge clk) disable iff (rst)
    accept && empty && (req.op == idq_pkg::OP_POP_FRONT || req.op == idq_pkg::OP_POP_REAR)
    |=> entry_count == '0 && $stable(head_slot))
    else $error("pop on empty changed state");

endmodule

// ----- rtl/core/idq_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed deque store command queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module idq_cmd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       fill;

  assign full     = (fill == 2'd2);
  assign valid    = (fill != 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !valid))
    else $error("command queue underflow");

endmodule

// ----- rtl/core/idq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed deque store back end
// Carries out memory writes and reads in order and holds the response word
// in an output register.
// ----------------------------------------------------------------------------
module idq_back #(
  parameter int DEPTH     = idq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = idq_pkg::WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  input  idq_pkg::cmd_ctrl_t       cmd_ctrl,
  input  logic [$clog2(DEPTH)-1:0] cmd_slot,
  input  logic [WORD_BITS-1:0]     cmd_value,
  output logic                     cmd_pop,
  idq_rsp_if.source                rsp
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data;
  idq_pkg::cmd_ctrl_t   ctrl_q;
  logic                 out_valid;

  assign cmd_pop = cmd_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_ctrl.wr) begin
      mem[cmd_slot] <= cmd_value;
    end
    if (cmd_pop && cmd_ctrl.rd) begin
      rd_data <= mem[cmd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      ctrl_q <= cmd_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_pop) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = ctrl_q.status;
  assign rsp.count      = ctrl_q.count;
  assign rsp.read_value = ctrl_q.rd ? $signed(32'(rd_data)) : '0;

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> !(cmd_ctrl.wr && cmd_ctrl.rd))
    else $error("command both reads and writes");

  a_ok_on_access: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (cmd_ctrl.wr || cmd_ctrl.rd) |-> cmd_ctrl.status == idq_pkg::ST_OK)
    else $error("memory access with error status");

endmodule
